/* rtl/ols_pkg.sv */
// ----------------------------------------------------------------------------
// ols_pkg: shared types and constants for the ordered list store
// Request kinds, status codes, controller states and command/status structs.
// ----------------------------------------------------------------------------
package ols_pkg;

  localparam int CAPACITY    = 64;
  localparam int VALUE_WIDTH = 32;
  localparam int IDX_W       = $clog2(CAPACITY);
  localparam int CNT_W       = $clog2(CAPACITY + 1);

  typedef enum logic [2:0] {
    KIND_APPEND  = 3'd0,
    KIND_PREPEND = 3'd1,
    KIND_INSERT  = 3'd2,
    KIND_SET     = 3'd3,
    KIND_DELETE  = 3'd4,
    KIND_FIND    = 3'd5,
    KIND_GET     = 3'd6,
    KIND_CLEAR   = 3'd7
  } kind_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_INVALID   = 2'd1,
    ST_FULL      = 2'd2,
    ST_NOT_FOUND = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SHIFT,
    S_SCAN,
    S_GET,
    S_DONE
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic             load;       // capture request
    logic             rd_en;      // read memory at rd_addr
    logic [IDX_W-1:0] rd_addr;
    logic             wr_en;      // write memory
    logic [IDX_W-1:0] wr_addr;
    logic             wr_from_rd; // write data is last read data (shift)
    logic             cmp;        // compare last read data with request value
    logic             take_get;   // latch last read data as result
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic             match;
  } dp_stat_t;

endpackage

/* rtl/ols_ram.sv */
// ----------------------------------------------------------------------------
// ols_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle.
// ----------------------------------------------------------------------------
module ols_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

/* rtl/ols_datapath.sv */
// ----------------------------------------------------------------------------
// ols_datapath: entry memory, request value register and result capture
// Executes read, write, shift and compare commands from the controller.
// ----------------------------------------------------------------------------
module ols_datapath (
  input  logic                          clk,
  input  ols_pkg::dp_cmd_t              cmd,
  input  logic [ols_pkg::VALUE_WIDTH-1:0] in_value,
  output ols_pkg::dp_stat_t             stat,
  output logic [ols_pkg::VALUE_WIDTH-1:0] get_value
);
  import ols_pkg::*;

  logic [VALUE_WIDTH-1:0] rd_data;
  logic [VALUE_WIDTH-1:0] wr_data;
  logic [VALUE_WIDTH-1:0] req_value;

  // request value and get result
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_value <= in_value;
    end
    if (cmd.take_get) begin
      get_value <= rd_data;
    end
  end

  // a write in the capture cycle takes the incoming value directly
  assign wr_data    = cmd.wr_from_rd ? rd_data :
                      (cmd.load ? in_value : req_value);
  assign stat.match = cmd.cmp && (rd_data == req_value);

  ols_ram #(.WIDTH(VALUE_WIDTH), .DEPTH(CAPACITY)) u_ram (
    .clk     (clk),
    .wr_en   (cmd.wr_en),
    .wr_addr (cmd.wr_addr),
    .wr_data (wr_data),
    .rd_en   (cmd.rd_en),
    .rd_addr (cmd.rd_addr),
    .rd_data (rd_data)
  );

endmodule

/* rtl/ols_ctrl.sv */
// ----------------------------------------------------------------------------
// ols_ctrl: request controller for the ordered list store
// Checks requests, sequences shifts and scans, and holds the result register.
// ----------------------------------------------------------------------------
module ols_ctrl (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        req_valid,
  output logic                        req_ready,
  input  logic [2:0]                  req_kind,
  input  logic [ols_pkg::IDX_W-1:0]   req_pos,
  input  logic                        val_zero,
  output logic                        rsp_valid,
  input  logic                        rsp_ready,
  output logic [1:0]                  rsp_status,
  output logic                        rsp_use_get,
  output logic [ols_pkg::IDX_W-1:0]   rsp_fpos,
  output logic [ols_pkg::CNT_W-1:0]   rsp_count,
  output ols_pkg::dp_cmd_t            cmd,
  input  ols_pkg::dp_stat_t           stat
);
  import ols_pkg::*;

  state_t           state, state_next;
  logic [CNT_W-1:0] count, count_next;
  kind_t            kind, kind_next;
  logic [CNT_W-1:0] ptr, ptr_next;   // shift or scan pointer
  logic [CNT_W-1:0] stop, stop_next; // shift end index
  logic             rd_pend, rd_pend_next;
  logic [1:0]       status, status_next;
  logic [IDX_W-1:0] fpos, fpos_next;
  logic             use_get, use_get_next;
  logic [CNT_W-1:0] pos_ext;
  logic             full;

  assign pos_ext = CNT_W'(req_pos);
  assign full    = (count >= CNT_W'(CAPACITY));

  // state and control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      count   <= '0;
      rd_pend <= 1'b0;
    end else begin
      state   <= state_next;
      count   <= count_next;
      rd_pend <= rd_pend_next;
    end
    kind    <= kind_next;
    ptr     <= ptr_next;
    stop    <= stop_next;
    status  <= status_next;
    fpos    <= fpos_next;
    use_get <= use_get_next;
  end

  // next state and datapath commands
  always_comb begin
    state_next   = state;
    count_next   = count;
    kind_next    = kind;
    ptr_next     = ptr;
    stop_next    = stop;
    rd_pend_next = 1'b0;
    status_next  = status;
    fpos_next    = fpos;
    use_get_next = use_get;
    cmd          = '0;
    req_ready    = 1'b0;
    rsp_valid    = 1'b0;
    unique case (state)
      S_IDLE: begin
        req_ready = 1'b1;
        if (req_valid) begin
          cmd.load     = 1'b1;
          kind_next    = kind_t'(req_kind);
          status_next  = ST_OK;
          fpos_next    = '0;
          use_get_next = 1'b0;
          state_next   = S_DONE;
          unique case (kind_t'(req_kind))
            KIND_APPEND, KIND_PREPEND, KIND_INSERT: begin
              if (val_zero || (req_kind == KIND_INSERT && pos_ext > count)) begin
                status_next = ST_INVALID;
              end else if (full) begin
                status_next = ST_FULL;
              end else begin
                // shift entries [at, count) up by one, from the top down
                ptr_next  = count;
                stop_next = (req_kind == KIND_APPEND) ? count :
                            (req_kind == KIND_PREPEND) ? '0 : pos_ext;
                state_next = S_SHIFT;
              end
            end
            KIND_SET: begin
              if (val_zero || pos_ext >= count) begin
                status_next = ST_INVALID;
              end else begin
                cmd.wr_en   = 1'b1;
                cmd.wr_addr = req_pos;
              end
            end
            KIND_DELETE: begin
              if (pos_ext >= count) begin
                status_next = ST_INVALID;
              end else begin
                // shift entries (pos, count) down, bottom up
                ptr_next   = pos_ext;
                stop_next  = count - CNT_W'(1);
                state_next = S_SHIFT;
              end
            end
            KIND_FIND: begin
              status_next = ST_NOT_FOUND;
              ptr_next    = '0;
              state_next  = S_SCAN;
            end
            KIND_GET: begin
              if (pos_ext >= count) begin
                status_next = ST_INVALID;
              end else begin
                cmd.rd_en   = 1'b1;
                cmd.rd_addr = req_pos;
                state_next  = S_GET;
              end
            end
            KIND_CLEAR: begin
              count_next = '0;
            end
            default: ;
          endcase
        end
      end
      S_SHIFT: begin
        // read one step, write it the next cycle
        if (kind == KIND_DELETE) begin
          if (rd_pend) begin
            cmd.wr_en      = 1'b1;
            cmd.wr_addr    = IDX_W'(ptr - CNT_W'(1));
            cmd.wr_from_rd = 1'b1;
          end
          if (ptr < stop) begin
            cmd.rd_en    = 1'b1;
            cmd.rd_addr  = IDX_W'(ptr + CNT_W'(1));
            ptr_next     = ptr + CNT_W'(1);
            rd_pend_next = 1'b1;
          end else if (!rd_pend) begin
            count_next = count - CNT_W'(1);
            state_next = S_DONE;
          end
        end else begin
          if (rd_pend) begin
            cmd.wr_en      = 1'b1;
            cmd.wr_addr    = IDX_W'(ptr + CNT_W'(1));
            cmd.wr_from_rd = 1'b1;
          end
          if (ptr > stop) begin
            cmd.rd_en    = 1'b1;
            cmd.rd_addr  = IDX_W'(ptr - CNT_W'(1));
            ptr_next     = ptr - CNT_W'(1);
            rd_pend_next = 1'b1;
          end else if (!rd_pend) begin
            cmd.wr_en   = 1'b1;
            cmd.wr_addr = IDX_W'(stop);
            count_next  = count + CNT_W'(1);
            state_next  = S_DONE;
          end
        end
      end
      S_SCAN: begin
        // one read issued per cycle, compared the cycle after
        cmd.cmp = rd_pend;
        if (rd_pend && stat.match) begin
          status_next = ST_OK;
          fpos_next   = IDX_W'(ptr - CNT_W'(1));
          state_next  = S_DONE;
        end else if (ptr < count) begin
          cmd.rd_en    = 1'b1;
          cmd.rd_addr  = IDX_W'(ptr);
          ptr_next     = ptr + CNT_W'(1);
          rd_pend_next = 1'b1;
        end else begin
          state_next = S_DONE;
        end
      end
      S_GET: begin
        cmd.take_get = 1'b1;
        use_get_next = 1'b1;
        state_next   = S_DONE;
      end
      S_DONE: begin
        rsp_valid = 1'b1;
        if (rsp_ready) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  assign rsp_status  = status;
  assign rsp_fpos    = fpos;
  assign rsp_count   = count;
  assign rsp_use_get = use_get;

  // count never exceeds capacity
  a_count_cap: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(CAPACITY)) else $error("count above capacity");

  // a request is only taken in idle
  a_req_idle: assert property (@(posedge clk) disable iff (rst)
    (req_valid && req_ready) |=> (state != S_IDLE)) else $error("request lost");

  // count changes by at most one per cycle, except clear
  a_count_step: assert property (@(posedge clk) disable iff (rst)
    (state != S_IDLE) |=> (count == $past(count) || count == $past(count) + CNT_W'(1)
      || count == $past(count) - CNT_W'(1))) else $error("count jump");

  // a found position lies within the list
  a_fpos: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && kind == KIND_FIND && status == ST_OK) |-> (CNT_W'(fpos) < count))
    else $error("found position out of range");

endmodule

/* rtl/ordered_list_store_unit.sv */
// ----------------------------------------------------------------------------
// ordered_list_store_unit: fixed-capacity ordered list of nonzero values
// Append, prepend, insert, set, delete, find, get and clear on one entry RAM.
// ----------------------------------------------------------------------------
// Set, clear and rejected requests answer straight from idle; get reads the entry
// in a get state first; append writes the new entry in the shift state.
// Insert/prepend/delete move the entries in the shift state, one entry per cycle
// through the single read and write port of the entry RAM.
// Find reads entries from index 0 upward until a hit or the end of the list.
// One request at a time; the next is taken in the cycle after the result is taken.
// Reset empties the list at once; entry RAM contents are not cleared.
module ordered_list_store_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [39:0] s_tdata,  // position[5:0], entry_value[37:6]
  input  logic [2:0]  s_tuser,  // kind[2:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [47:0] m_tdata   // status[1:0], read_value[33:2],
                                // found_position[39:34], entry_count[46:40]
);
  import ols_pkg::*;

  dp_cmd_t                cmd;
  dp_stat_t               stat;
  logic [VALUE_WIDTH-1:0] get_value;
  logic [VALUE_WIDTH-1:0] in_value;
  logic [1:0]             rsp_status;
  logic                   rsp_use_get;
  logic [IDX_W-1:0]       rsp_fpos;
  logic [CNT_W-1:0]       rsp_count;

  assign in_value = s_tdata[6 +: VALUE_WIDTH];

  ols_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .req_valid   (s_tvalid),
    .req_ready   (s_tready),
    .req_kind    (s_tuser),
    .req_pos     (s_tdata[5:0]),
    .val_zero    (in_value == '0),
    .rsp_valid   (m_tvalid),
    .rsp_ready   (m_tready),
    .rsp_status  (rsp_status),
    .rsp_use_get (rsp_use_get),
    .rsp_fpos    (rsp_fpos),
    .rsp_count   (rsp_count),
    .cmd         (cmd),
    .stat        (stat)
  );

  ols_datapath u_dp (
    .clk       (clk),
    .cmd       (cmd),
    .in_value  (in_value),
    .stat      (stat),
    .get_value (get_value)
  );

  // result packing
  assign m_tdata = {1'b0, rsp_count, rsp_fpos,
                    (rsp_use_get ? get_value : {VALUE_WIDTH{1'b0}}), rsp_status};

endmodule
